// ===== rtl/core/llfd_pkg.sv =====
// shared types, constants and register codes for the late-latch frame deadline block
// no dependencies; imported by llfd_calc and late_latch_frame_deadline
package llfd_pkg;

    localparam int EST_W      = 27;
    localparam int DRAW_W     = 32;
    localparam int IVL_W      = 30;
    localparam int TIME_W     = 64;
    localparam int LEAD_W     = EST_W + 2;
    localparam int GATE_W     = EST_W + 3;
    localparam int REG_IDX_W  = 3;
    localparam int CFG_DATA_W = EST_W;

    // ceil(d/50) = floor(floor((d+49)/2)/25), divide by 25 via reciprocal
    localparam int RECIP_W     = 28;
    localparam int RECIP_SHIFT = 32;
    localparam logic [EST_W:0]       CEIL_BIAS = (EST_W+1)'(49);
    localparam logic [RECIP_W-1:0]   RECIP_25  = RECIP_W'(171798692);

    typedef enum logic
    {
        CMD_SAMPLE = 1'b0,
        CMD_FRAME  = 1'b1
    } cmd_t;

    typedef enum logic [REG_IDX_W-1:0]
    {
        REG_ENABLE     = 3'd0,
        REG_REDZONE    = 3'd1,
        REG_COMPOSITE  = 3'd2,
        REG_START_DRAW = 3'd3,
        REG_MIN_DRAW   = 3'd4,
        REG_MAX_DRAW   = 3'd5,
        REG_MIN_GAIN   = 3'd6
    } reg_idx_t;

    typedef struct packed
    {
        logic             enable;
        logic [EST_W-1:0] redzone_ns;
        logic [EST_W-1:0] composite_ns;
        logic [EST_W-1:0] start_draw_ns;
        logic [EST_W-1:0] min_draw_ns;
        logic [EST_W-1:0] max_draw_ns;
        logic [EST_W-1:0] min_gain_ns;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        enable:        1'b1,
        redzone_ns:    EST_W'(1650000),
        composite_ns:  EST_W'(2400000),
        start_draw_ns: EST_W'(3000000),
        min_draw_ns:   EST_W'(200000),
        max_draw_ns:   EST_W'(10000000),
        min_gain_ns:   EST_W'(100000)
    };

    typedef struct packed
    {
        cmd_t              command;
        logic [DRAW_W-1:0] draw_ns;
        logic              is_game;
        logic              tearing_ok;
        logic              from_latch_timer;
        logic              vrr_on;
        logic              game_vrr_on;
        logic              direct_scanout;
        logic [IVL_W-1:0]  refresh_ns;
        logic [TIME_W-1:0] present_at_ns;
        logic [TIME_W-1:0] now_ns;
    } item_t;

    typedef struct packed
    {
        logic              defer;
        logic [TIME_W-1:0] fire_time_ns;
    } res_t;

endpackage

// ===== rtl/core/late_latch_frame_deadline.sv =====
// late-latch frame deadline: top level with config registers, input and result stages
// the result register loads from the input register whenever it is empty or not stalled
// throughput: one item per clock while out_stall is low; estimate and armed flag feed back
// combinationally via llfd_calc, a stalled result holds while one more item waits in the input reg
// reset: config registers take their defaults, estimate and armed flag clear, stages empty
// depends on llfd_pkg and llfd_calc
module late_latch_frame_deadline
(
    input  logic                                clk,
    input  logic                                rst_n,
    // input channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                command,
    input  logic [llfd_pkg::DRAW_W-1:0]         draw_ns,
    input  logic                                is_game,
    input  logic                                tearing_ok,
    input  logic                                from_latch_timer,
    input  logic                                vrr_on,
    input  logic                                game_vrr_on,
    input  logic                                direct_scanout,
    input  logic [llfd_pkg::IVL_W-1:0]          refresh_ns,
    input  logic [llfd_pkg::TIME_W-1:0]         present_at_ns,
    input  logic [llfd_pkg::TIME_W-1:0]         now_ns,
    // result channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                defer,
    output logic [llfd_pkg::TIME_W-1:0]         fire_time_ns,
    output logic [llfd_pkg::EST_W-1:0]          draw_estimate_ns,
    output logic                                armed,
    // configuration write port
    input  logic                                cfg_write,
    input  logic [llfd_pkg::REG_IDX_W-1:0]      cfg_index,
    input  logic [llfd_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import llfd_pkg::*;

    // config registers
    cfg_t               cfg_reg;
    cfg_t               cfg_next;

    // input stage
    logic               s1_valid_reg;
    logic               s1_valid_next;
    item_t              s1_item_reg;
    item_t              in_item;

    // block state
    logic [EST_W-1:0]   est_reg;
    logic [EST_W-1:0]   est_next;
    logic               armed_reg;
    logic               armed_next;

    // result stage
    logic               out_valid_reg;
    logic               out_valid_next;
    res_t               out_res_reg;
    logic [EST_W-1:0]   out_est_reg;
    logic               out_armed_reg;

    // handshake
    logic               in_xfer;
    logic               advance;
    res_t               calc_res;

    // config write decode, unknown index is ignored
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (reg_idx_t'(cfg_index))
                REG_ENABLE:     cfg_next.enable        = cfg_data[0];
                REG_REDZONE:    cfg_next.redzone_ns    = cfg_data;
                REG_COMPOSITE:  cfg_next.composite_ns  = cfg_data;
                REG_START_DRAW: cfg_next.start_draw_ns = cfg_data;
                REG_MIN_DRAW:   cfg_next.min_draw_ns   = cfg_data;
                REG_MAX_DRAW:   cfg_next.max_draw_ns   = cfg_data;
                REG_MIN_GAIN:   cfg_next.min_gain_ns   = cfg_data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // pack the input ports
    always_comb
    begin
        in_item.command          = cmd_t'(command);
        in_item.draw_ns          = draw_ns;
        in_item.is_game          = is_game;
        in_item.tearing_ok       = tearing_ok;
        in_item.from_latch_timer = from_latch_timer;
        in_item.vrr_on           = vrr_on;
        in_item.game_vrr_on      = game_vrr_on;
        in_item.direct_scanout   = direct_scanout;
        in_item.refresh_ns       = refresh_ns;
        in_item.present_at_ns    = present_at_ns;
        in_item.now_ns           = now_ns;
    end

    // the held item moves on whenever the result register is empty or draining;
    // the input register refills in that same cycle
    assign advance  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !advance;
    assign in_xfer  = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_xfer)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // estimate update and deferral decision for the held item
    llfd_calc u_calc
    (
        .item       (s1_item_reg),
        .cfg        (cfg_reg),
        .est        (est_reg),
        .armed      (armed_reg),
        .est_next   (est_next),
        .armed_next (armed_next),
        .res        (calc_res)
    );

    // control state and block state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            est_reg       <= '0;
            armed_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                est_reg   <= est_next;
                armed_reg <= armed_next;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_item_reg <= in_item;
        end
        if (advance)
        begin
            out_res_reg   <= calc_res;
            out_est_reg   <= est_next;
            out_armed_reg <= armed_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign defer            = out_res_reg.defer;
    assign fire_time_ns     = out_res_reg.fire_time_ns;
    assign draw_estimate_ns = out_est_reg;
    assign armed            = out_armed_reg;

`ifndef SYNTHESIS
    // a deferred result always reports the latch as armed
    a_defer_arms: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_res_reg.defer) |-> out_armed_reg)
        else $error("deferred result without armed latch");

    // fire time is zero unless the commit is deferred
    a_fire_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_res_reg.defer) |-> (out_res_reg.fire_time_ns == '0))
        else $error("fire time set without deferral");

    // the input side only stalls while an item is held
    a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg)
        else $error("input stalled with empty input stage");

    // estimate changes only when a sample moves to the result stage
    a_est_sample: assert property (@(posedge clk) disable iff (!rst_n)
        (est_reg != $past(est_reg)) |->
        $past(advance && (s1_item_reg.command == CMD_SAMPLE)))
        else $error("estimate changed without a sample transfer");
`endif

endmodule

// ===== rtl/core/llfd_calc.sv =====
// per-item update logic: sample tracking and frame deferral decision
// depends on llfd_pkg
module llfd_calc
(
    input  llfd_pkg::item_t                item,
    input  llfd_pkg::cfg_t                 cfg,
    input  logic [llfd_pkg::EST_W-1:0]     est,
    input  logic                           armed,
    output logic [llfd_pkg::EST_W-1:0]     est_next,
    output logic                           armed_next,
    output llfd_pkg::res_t                 res
);
    import llfd_pkg::*;

    logic [DRAW_W-1:0]              clamp_lo;
    logic [EST_W-1:0]               sample;
    logic [EST_W-1:0]               base;
    logic [EST_W-1:0]               gap;
    logic [EST_W:0]                 ceil_num;
    logic [EST_W+RECIP_W-1:0]       prod;
    logic [EST_W-1:0]               step;
    logic [EST_W-1:0]               sample_est;
    logic [LEAD_W-1:0]              lead;
    logic [GATE_W-1:0]              gate;
    logic [TIME_W-1:0]              span;
    logic                           eligible;
    logic                           do_defer;

    // sample path: clamp low then high, jump up or decay by (e*98+s*2)/100
    always_comb
    begin
        clamp_lo = (item.draw_ns < DRAW_W'(cfg.min_draw_ns)) ?
                   DRAW_W'(cfg.min_draw_ns) : item.draw_ns;
        sample   = (clamp_lo > DRAW_W'(cfg.max_draw_ns)) ?
                   cfg.max_draw_ns : clamp_lo[EST_W-1:0];
        base     = (est == '0) ? cfg.start_draw_ns : est;
        gap      = base - sample;
        // decayed value equals base - ceil(gap/50)
        ceil_num = {1'b0, gap} + CEIL_BIAS;
        prod     = (EST_W+RECIP_W)'(ceil_num[EST_W:1]) * (EST_W+RECIP_W)'(RECIP_25);
        step     = EST_W'(prod >> RECIP_SHIFT);
        sample_est = (sample > base) ? sample : (base - step);
    end

    // frame path: lead and margin gate, lead two bits wider than its terms, gate one bit wider than lead
    always_comb
    begin
        lead = LEAD_W'(base) + LEAD_W'(cfg.redzone_ns) +
               (item.direct_scanout ? '0 : LEAD_W'(cfg.composite_ns));
        gate = GATE_W'(lead) + GATE_W'(cfg.min_gain_ns);
        span = item.present_at_ns - item.now_ns;
        eligible = cfg.enable && item.is_game && !item.tearing_ok &&
                   !item.vrr_on && !item.game_vrr_on &&
                   (item.refresh_ns != '0);
        do_defer = eligible && (item.present_at_ns > item.now_ns) &&
                   (span > TIME_W'(gate));
    end

    always_comb
    begin
        est_next         = est;
        armed_next       = armed;
        res.defer        = 1'b0;
        res.fire_time_ns = '0;
        case (item.command)
            CMD_SAMPLE:
            begin
                est_next = sample_est;
            end
            CMD_FRAME:
            begin
                if (item.from_latch_timer)
                begin
                    armed_next = 1'b0;
                end
                else if (do_defer)
                begin
                    armed_next       = 1'b1;
                    res.defer        = 1'b1;
                    res.fire_time_ns = item.present_at_ns - TIME_W'(lead);
                end
            end
            default:
            begin
                est_next = est;
            end
        endcase
    end

endmodule
